@@ design/mfs_pkg.sv @@
package mfs_pkg;

  localparam int NODE_W   = 6;
  localparam int NODES    = 64;
  localparam int EDGE_W   = 8;
  localparam int EDGES    = 256;
  localparam int EIDX_W   = 9;
  localparam int CAP_W    = 32;
  localparam int FLOW_W   = 33;
  localparam int TOTAL_W  = 40;
  localparam int CNT_W    = 7;
  localparam int TC_W     = NODE_W + CAP_W;

  localparam logic [EIDX_W-1:0]  NO_EDGE    = 9'd256;
  localparam logic [TOTAL_W-1:0] FLOW_LIMIT = {TOTAL_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_SOLVE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ENDS  = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_SOURCE     = 2'd1;
  localparam logic [1:0] REG_SINK       = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_ADD3,
    S_BINIT, S_BPOP, S_BU, S_BU2, S_BE,
    S_DTOP, S_DCUR, S_DEDGE, S_DCHK,
    S_DPOP, S_DPOP2, S_DPOP3, S_DPOP4,
    S_GRD, S_GE, S_GR,
    S_PRD, S_PE, S_PF, S_PR,
    S_FIN
  } state_t;

  // remaining capacity; never negative, and never above 2^32-1
  function automatic logic [FLOW_W-1:0] resid(input logic [CAP_W-1:0] cap,
                                              input logic [FLOW_W-1:0] flow);
    logic [FLOW_W:0] d;
    d = {2'b00, cap} - {flow[FLOW_W-1], flow};
    resid = d[FLOW_W] ? '0 : d[FLOW_W-1:0];
  endfunction

endpackage

@@ design/max_flow_solver_top.sv @@
// Maximum-flow engine (level graph plus blocking flow).
// Input stream: in_tuser carries the item kind (add edge, solve, clear);
// in_tdata carries from_node, to_node and capacity. Every accepted beat yields
// exactly one result beat on the out_ side: status and max_flow.
// Add edge: writes the forward and reverse edge records in S_ADD0 to S_ADD3,
// then the result. Clear and rejected items go straight to the result state.
// Solve: data dependent. Each level pass visits the queued nodes and scans their
// edges; the depth-first search tries edges, retreats and augments each path. All of
// it runs through synchronous edge and node memories, each with one registered read
// port and one write port. Once solved, further solves return the cached flow
// without a new search until a clear beat.
// One item is worked on at a time. A finished result sits in an output
// register, so the next input beat is taken while the receiver stalls; the
// following result then waits until that register is free.
// Reset (synchronous, rst_n low) empties the graph, clears the cached result
// and loads node_count 64, source 0, sink 1. Registers must be written over the
// APB port only while the block is idle; the block itself does not enforce it.
module max_flow_solver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // from_node[5:0], to_node[11:6], capacity[43:12]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], max_flow[41:2]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mfs_pkg::*;

  state_t state_r, state_nxt;

  logic [6:0]          node_count_r;
  logic [NODE_W-1:0]   source_r, sink_r;
  logic [NODE_W-1:0]   from_r, from_nxt, to_r, to_nxt;
  logic [CAP_W-1:0]    cap_r, cap_nxt;
  logic [EIDX_W-1:0]   edges_used_r, edges_used_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic                solved_r, solved_nxt;
  logic [NODES-1:0]    fvld_r, fvld_nxt, lvld_r, lvld_nxt, cset_r, cset_nxt;
  logic [CNT_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]    depth_r, depth_nxt, idx_r, idx_nxt;
  logic [NODE_W-1:0]   u_r, u_nxt, v_r, v_nxt, ulev_r, ulev_nxt;
  logic [EIDX_W-1:0]   e_r, e_nxt, next_r, next_nxt;
  logic [EDGE_W-1:0]   pe_r, pe_nxt;
  logic [FLOW_W-1:0]   res_r, res_nxt, bneck_r, bneck_nxt;
  logic [1:0]          rstat_r, rstat_nxt;
  logic [TOTAL_W-1:0]  rflow_r, rflow_nxt;
  logic                out_tvalid_r;
  logic [47:0]         out_tdata_r;

  // memories
  logic [TC_W-1:0]     tc_mem   [EDGES];
  logic [FLOW_W-1:0]   flow_mem [EDGES];
  logic [EIDX_W-1:0]   next_mem [EDGES];
  logic [EDGE_W-1:0]   first_mem[NODES];
  logic [EDGE_W-1:0]   last_mem [NODES];
  logic [NODE_W-1:0]   level_mem[NODES];
  logic [EIDX_W-1:0]   cur_mem  [NODES];
  logic [NODE_W-1:0]   queue_mem[NODES];
  logic [EDGE_W-1:0]   stack_mem[NODES];

  logic                tc_we, flow_we, next_we, first_we, last_we;
  logic                level_we, cur_we, queue_we, stack_we;
  logic [EDGE_W-1:0]   tc_wa, tc_ra, flow_wa, flow_ra, next_wa, next_ra;
  logic [NODE_W-1:0]   first_wa, first_ra, last_wa, last_ra, level_wa, level_ra;
  logic [NODE_W-1:0]   cur_wa, cur_ra, queue_wa, queue_ra, stack_wa, stack_ra;
  logic [TC_W-1:0]     tc_wd, tc_q;
  logic [FLOW_W-1:0]   flow_wd, flow_q;
  logic [EIDX_W-1:0]   next_wd, next_q, cur_wd, cur_q;
  logic [EDGE_W-1:0]   first_wd, first_q, last_wd, last_q, stack_wd, stack_q;
  logic [NODE_W-1:0]   level_wd, level_q, queue_wd, queue_q;

  always_ff @(posedge clk) begin
    tc_q <= tc_mem[tc_ra];
    if (tc_we) tc_mem[tc_wa] <= tc_wd;
    flow_q <= flow_mem[flow_ra];
    if (flow_we) flow_mem[flow_wa] <= flow_wd;
    next_q <= next_mem[next_ra];
    if (next_we) next_mem[next_wa] <= next_wd;
    first_q <= first_mem[first_ra];
    if (first_we) first_mem[first_wa] <= first_wd;
    last_q <= last_mem[last_ra];
    if (last_we) last_mem[last_wa] <= last_wd;
    level_q <= level_mem[level_ra];
    if (level_we) level_mem[level_wa] <= level_wd;
    cur_q <= cur_mem[cur_ra];
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    queue_q <= queue_mem[queue_ra];
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    stack_q <= stack_mem[stack_ra];
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
  end

  // input decode
  logic [NODE_W-1:0] in_from, in_to;
  logic [CAP_W-1:0]  in_cap;
  logic [6:0]        n_eff;
  logic              in_acc, range_bad, ends_bad, store_full, res_free;
  assign in_from = in_tdata[5:0];
  assign in_to   = in_tdata[11:6];
  assign in_cap  = in_tdata[43:12];
  assign n_eff   = (node_count_r > 7'd64) ? 7'd64 : node_count_r;
  assign in_acc  = in_tvalid && in_tready;
  assign range_bad  = ({1'b0, in_from} >= n_eff) || ({1'b0, in_to} >= n_eff);
  assign ends_bad   = ({1'b0, source_r} >= n_eff) || ({1'b0, sink_r} >= n_eff)
                      || (source_r == sink_r);
  assign store_full = edges_used_r > EIDX_W'(EDGES - 2);
  assign res_free   = !out_tvalid_r || out_tready;

  // derived values
  logic [EIDX_W-1:0] cur_eff, e_plus1;
  logic [FLOW_W-1:0] edge_res;
  logic [TOTAL_W:0]  total_sum;
  assign cur_eff   = cset_r[u_r] ? cur_q : (fvld_r[u_r] ? {1'b0, first_q} : NO_EDGE);
  assign edge_res  = resid(tc_q[CAP_W-1:0], flow_q);
  assign e_plus1   = edges_used_r + EIDX_W'(1);
  assign total_sum = {1'b0, total_r} + {{(TOTAL_W-FLOW_W+1){1'b0}}, bneck_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_tuser == KIND_ADD && !range_bad && !store_full) state_nxt = S_ADD0;
          else if (in_tuser == KIND_SOLVE && !ends_bad && !solved_r) state_nxt = S_BINIT;
          else state_nxt = S_FIN;
        end
      end
      S_ADD0:  state_nxt = S_ADD1;
      S_ADD1:  state_nxt = S_ADD2;
      S_ADD2:  state_nxt = S_ADD3;
      S_ADD3:  state_nxt = S_FIN;
      S_BINIT: state_nxt = S_BPOP;
      S_BPOP: begin
        if (head_r == tail_r) state_nxt = lvld_r[sink_r] ? S_DTOP : S_FIN;
        else state_nxt = S_BU;
      end
      S_BU:  state_nxt = S_BU2;
      S_BU2: state_nxt = fvld_r[u_r] ? S_BE : S_BPOP;
      S_BE:  state_nxt = (next_q == NO_EDGE) ? S_BPOP : S_BE;
      S_DTOP: state_nxt = (u_r == sink_r) ? S_GRD : S_DCUR;
      S_DCUR: begin
        if (cur_eff != NO_EDGE) state_nxt = S_DEDGE;
        else state_nxt = (depth_r == '0) ? S_BINIT : S_DPOP;
      end
      S_DEDGE: state_nxt = S_DCHK;
      S_DCHK:  state_nxt = S_DTOP;
      S_DPOP:  state_nxt = S_DPOP2;
      S_DPOP2: state_nxt = S_DPOP3;
      S_DPOP3: state_nxt = S_DPOP4;
      S_DPOP4: state_nxt = S_DTOP;
      S_GRD:   state_nxt = (idx_r == depth_r) ? S_PRD : S_GE;
      S_GE:    state_nxt = S_GR;
      S_GR:    state_nxt = S_GRD;
      S_PRD:   state_nxt = (idx_r == depth_r) ? S_DTOP : S_PE;
      S_PE:    state_nxt = S_PF;
      S_PF:    state_nxt = S_PR;
      S_PR:    state_nxt = S_PRD;
      S_FIN:   state_nxt = res_free ? S_IDLE : S_FIN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    from_nxt = from_r; to_nxt = to_r; cap_nxt = cap_r;
    edges_used_nxt = edges_used_r; total_nxt = total_r; solved_nxt = solved_r;
    fvld_nxt = fvld_r; lvld_nxt = lvld_r; cset_nxt = cset_r;
    head_nxt = head_r; tail_nxt = tail_r; depth_nxt = depth_r; idx_nxt = idx_r;
    u_nxt = u_r; v_nxt = v_r; ulev_nxt = ulev_r; e_nxt = e_r; next_nxt = next_r;
    pe_nxt = pe_r; res_nxt = res_r; bneck_nxt = bneck_r;
    rstat_nxt = rstat_r; rflow_nxt = rflow_r;

    tc_we = 1'b0; tc_wa = edges_used_r[EDGE_W-1:0]; tc_wd = {to_r, cap_r};
    tc_ra = e_r[EDGE_W-1:0];
    flow_we = 1'b0; flow_wa = edges_used_r[EDGE_W-1:0]; flow_wd = '0;
    flow_ra = e_r[EDGE_W-1:0];
    next_we = 1'b0; next_wa = edges_used_r[EDGE_W-1:0]; next_wd = NO_EDGE;
    next_ra = e_r[EDGE_W-1:0];
    first_we = 1'b0; first_wa = from_r; first_wd = edges_used_r[EDGE_W-1:0];
    first_ra = u_r;
    last_we = 1'b0; last_wa = from_r; last_wd = edges_used_r[EDGE_W-1:0];
    last_ra = from_r;
    level_we = 1'b0; level_wa = source_r; level_wd = '0; level_ra = u_r;
    cur_we = 1'b0; cur_wa = u_r; cur_wd = next_r; cur_ra = u_r;
    queue_we = 1'b0; queue_wa = '0; queue_wd = source_r; queue_ra = head_r[NODE_W-1:0];
    stack_we = 1'b0; stack_wa = depth_r[NODE_W-1:0]; stack_wd = e_r[EDGE_W-1:0];
    stack_ra = idx_r[NODE_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        from_nxt = in_from; to_nxt = in_to; cap_nxt = in_cap;
        rstat_nxt = ST_OK; rflow_nxt = '0;
        if (in_acc) begin
          unique case (in_tuser)
            KIND_ADD: begin
              if (range_bad) rstat_nxt = ST_RANGE;
              else if (store_full) rstat_nxt = ST_FULL;
            end
            KIND_SOLVE: begin
              if (ends_bad) rstat_nxt = ST_BAD_ENDS;
              else if (solved_r) rflow_nxt = total_r;
              else solved_nxt = 1'b1;
            end
            KIND_CLEAR: begin
              fvld_nxt = '0; edges_used_nxt = '0; total_nxt = '0; solved_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_ADD0: begin
        tc_we = 1'b1; flow_we = 1'b1; next_we = 1'b1;
        last_ra = from_r;
      end
      S_ADD1: begin
        // hook the forward edge onto the tail of from_node's list
        if (fvld_r[from_r]) begin
          next_we = 1'b1; next_wa = last_q; next_wd = edges_used_r;
        end else begin
          first_we = 1'b1;
        end
        fvld_nxt[from_r] = 1'b1;
        last_we = 1'b1;
        tc_we = 1'b1; tc_wa = e_plus1[EDGE_W-1:0]; tc_wd = {from_r, {CAP_W{1'b0}}};
        flow_we = 1'b1; flow_wa = e_plus1[EDGE_W-1:0];
      end
      S_ADD2: begin
        next_we = 1'b1; next_wa = e_plus1[EDGE_W-1:0];
        last_ra = to_r;
      end
      S_ADD3: begin
        if (fvld_r[to_r]) begin
          next_we = 1'b1; next_wa = last_q; next_wd = e_plus1;
        end else begin
          first_we = 1'b1; first_wa = to_r; first_wd = e_plus1[EDGE_W-1:0];
        end
        fvld_nxt[to_r] = 1'b1;
        last_we = 1'b1; last_wa = to_r; last_wd = e_plus1[EDGE_W-1:0];
        edges_used_nxt = edges_used_r + EIDX_W'(2);
      end
      S_BINIT: begin
        lvld_nxt = '0; lvld_nxt[source_r] = 1'b1;
        level_we = 1'b1; queue_we = 1'b1;
        head_nxt = '0; tail_nxt = CNT_W'(1);
      end
      S_BPOP: begin
        queue_ra = head_r[NODE_W-1:0];
        if (head_r == tail_r) begin
          if (lvld_r[sink_r]) begin
            cset_nxt = '0; u_nxt = source_r; depth_nxt = '0;
          end else begin
            rflow_nxt = total_r;
          end
        end else begin
          head_nxt = head_r + CNT_W'(1);
        end
      end
      S_BU: begin
        u_nxt = queue_q;
        first_ra = queue_q; level_ra = queue_q;
      end
      S_BU2: begin
        ulev_nxt = level_q;
        tc_ra = first_q; flow_ra = first_q; next_ra = first_q;
      end
      S_BE: begin
        if (!lvld_r[tc_q[TC_W-1:CAP_W]] && edge_res != '0) begin
          lvld_nxt[tc_q[TC_W-1:CAP_W]] = 1'b1;
          level_we = 1'b1; level_wa = tc_q[TC_W-1:CAP_W]; level_wd = ulev_r + NODE_W'(1);
          queue_we = 1'b1; queue_wa = tail_r[NODE_W-1:0]; queue_wd = tc_q[TC_W-1:CAP_W];
          tail_nxt = tail_r + CNT_W'(1);
        end
        tc_ra = next_q[EDGE_W-1:0]; flow_ra = next_q[EDGE_W-1:0];
        next_ra = next_q[EDGE_W-1:0];
      end
      S_DTOP: begin
        cur_ra = u_r; first_ra = u_r; level_ra = u_r;
        idx_nxt = '0; bneck_nxt = {FLOW_W{1'b1}};
      end
      S_DCUR: begin
        ulev_nxt = level_q;
        e_nxt = cur_eff;
        tc_ra = cur_eff[EDGE_W-1:0]; flow_ra = cur_eff[EDGE_W-1:0];
        next_ra = cur_eff[EDGE_W-1:0];
        stack_ra = depth_r[NODE_W-1:0] - NODE_W'(1);
        if (cur_eff == NO_EDGE && depth_r != '0) depth_nxt = depth_r - CNT_W'(1);
      end
      S_DEDGE: begin
        v_nxt = tc_q[TC_W-1:CAP_W]; res_nxt = edge_res; next_nxt = next_q;
        level_ra = tc_q[TC_W-1:CAP_W];
      end
      S_DCHK: begin
        if (lvld_r[v_r] && ({1'b0, level_q} == {1'b0, ulev_r} + CNT_W'(1))
            && res_r != '0 && !depth_r[CNT_W-1]) begin
          stack_we = 1'b1;
          depth_nxt = depth_r + CNT_W'(1);
          u_nxt = v_r;
        end else begin
          cur_we = 1'b1; cset_nxt[u_r] = 1'b1;
        end
      end
      S_DPOP: begin
        tc_ra = {stack_q[EDGE_W-1:1], ~stack_q[0]};
      end
      S_DPOP2: begin
        u_nxt = tc_q[TC_W-1:CAP_W];
        cur_ra = tc_q[TC_W-1:CAP_W]; first_ra = tc_q[TC_W-1:CAP_W];
      end
      S_DPOP3: begin
        next_ra = cur_eff[EDGE_W-1:0];
      end
      S_DPOP4: begin
        cur_we = 1'b1; cur_wd = next_q; cset_nxt[u_r] = 1'b1;
      end
      S_GRD: begin
        stack_ra = idx_r[NODE_W-1:0];
        if (idx_r == depth_r) idx_nxt = '0;
      end
      S_GE: begin
        tc_ra = stack_q; flow_ra = stack_q;
      end
      S_GR: begin
        if (edge_res < bneck_r) bneck_nxt = edge_res;
        idx_nxt = idx_r + CNT_W'(1);
      end
      S_PRD: begin
        stack_ra = idx_r[NODE_W-1:0];
        if (idx_r == depth_r) begin
          total_nxt = total_sum[TOTAL_W] ? FLOW_LIMIT : total_sum[TOTAL_W-1:0];
          depth_nxt = '0; u_nxt = source_r;
        end
      end
      S_PE: begin
        pe_nxt = stack_q; flow_ra = stack_q;
      end
      S_PF: begin
        flow_we = 1'b1; flow_wa = pe_r; flow_wd = flow_q + bneck_r;
        flow_ra = {pe_r[EDGE_W-1:1], ~pe_r[0]};
      end
      S_PR: begin
        flow_we = 1'b1; flow_wa = {pe_r[EDGE_W-1:1], ~pe_r[0]};
        flow_wd = flow_q - bneck_r;
        idx_nxt = idx_r + CNT_W'(1);
      end
      S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= 7'd64;
      source_r     <= '0;
      sink_r       <= NODE_W'(1);
      edges_used_r <= '0;
      total_r      <= '0;
      solved_r     <= 1'b0;
      fvld_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edges_used_r <= edges_used_nxt;
      total_r      <= total_nxt;
      solved_r     <= solved_nxt;
      fvld_r       <= fvld_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        unique case (cfg_paddr[3:2])
          REG_NODE_COUNT: node_count_r <= cfg_pwdata[6:0];
          REG_SOURCE:     source_r     <= cfg_pwdata[NODE_W-1:0];
          REG_SINK:       sink_r       <= cfg_pwdata[NODE_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_FIN && res_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    from_r <= from_nxt; to_r <= to_nxt; cap_r <= cap_nxt;
    lvld_r <= lvld_nxt; cset_r <= cset_nxt;
    head_r <= head_nxt; tail_r <= tail_nxt; depth_r <= depth_nxt; idx_r <= idx_nxt;
    u_r <= u_nxt; v_r <= v_nxt; ulev_r <= ulev_nxt; e_r <= e_nxt; next_r <= next_nxt;
    pe_r <= pe_nxt; res_r <= res_nxt; bneck_r <= bneck_nxt;
    rstat_r <= rstat_nxt; rflow_r <= rflow_nxt;
    if (state_r == S_FIN && res_free) out_tdata_r <= {6'd0, rflow_r, rstat_r};
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_NODE_COUNT: cfg_prdata = {25'd0, node_count_r};
      REG_SOURCE:     cfg_prdata = {26'd0, source_r};
      REG_SINK:       cfg_prdata = {26'd0, sink_r};
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ design/mfs_checker.sv @@
module mfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        cfg_pready
);
  import mfs_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped under stall");

  // one item at a time: input closes right after a beat is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input open right after accept");

  // any error status carries zero flow
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[41:2] == '0)
    else $error("nonzero flow with error status");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind max_flow_solver_top mfs_checker u_mfs_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .cfg_pready(cfg_pready)
);

@@ tb/sv/max_flow_solver_checker.sv @@
`timescale 1ns / 1ps

module max_flow_solver_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending
);
  import mfs_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [TOTAL_W-1:0]  flow;
  } answer_t;

  answer_t answer_q[$];

  logic [CNT_W-1:0]   nodes_in_use;
  logic [NODE_W-1:0]  src, snk;
  logic [NODE_W-1:0]  e_to [EDGES];
  logic [CAP_W-1:0]   e_cap [EDGES];
  longint             e_flow [EDGES];
  int                 e_nxt [EDGES];
  int                 first_e [NODES], last_e [NODES];
  int                 lvl [NODES], cur [NODES], bfs_q [NODES], path [NODES];
  int                 used_edges;
  logic [TOTAL_W-1:0] flow_sum;
  bit                 have_flow;

  assign pending = answer_q.size();

  function automatic longint spare(int e);
    longint r;
    r = longint'(e_cap[e]) - e_flow[e];
    return r > 0 ? r : 0;
  endfunction

  function automatic void wipe_graph();
    for (int v = 0; v < NODES; v++) begin
      first_e[v] = EDGES;
      last_e[v] = EDGES;
    end
    used_edges = 0;
    flow_sum = '0;
    have_flow = 0;
  endfunction

  function automatic void chain(int v, int e);
    e_nxt[e] = EDGES;
    if (first_e[v] >= EDGES) first_e[v] = e;
    else e_nxt[last_e[v]] = e;
    last_e[v] = e;
  endfunction

  function automatic bit levels_reach(int s, int t);
    int hd, tl, u, e, w;
    hd = 0;
    tl = 0;
    for (int v = 0; v < NODES; v++) lvl[v] = -1;
    lvl[s] = 0;
    bfs_q[tl++] = s;
    while (hd < tl) begin
      u = bfs_q[hd++];
      e = first_e[u];
      while (e < EDGES) begin
        w = e_to[e];
        if (lvl[w] < 0 && spare(e) > 0 && tl < NODES) begin
          lvl[w] = lvl[u] + 1;
          bfs_q[tl++] = w;
        end
        e = e_nxt[e];
      end
    end
    return lvl[t] >= 0;
  endfunction

  function automatic void push_blocking(int s, int t);
    int depth, u, e, w, pe;
    longint b;
    longint room;
    depth = 0;
    u = s;
    for (int v = 0; v < NODES; v++) cur[v] = first_e[v];
    forever begin
      if (u == t) begin
        b = 64'h7fff_ffff_ffff_ffff;
        for (int i = 0; i < depth; i++) if (spare(path[i]) < b) b = spare(path[i]);
        for (int i = 0; i < depth; i++) begin
          e_flow[path[i]] += b;
          e_flow[path[i] ^ 1] -= b;
        end
        room = longint'(FLOW_LIMIT) - longint'(flow_sum);
        flow_sum = (b > room) ? FLOW_LIMIT : flow_sum + b[TOTAL_W-1:0];
        depth = 0;
        u = s;
        continue;
      end
      e = cur[u];
      if (e >= EDGES) begin
        if (depth == 0) break;
        pe = path[--depth];
        u = e_to[pe ^ 1];
        cur[u] = e_nxt[cur[u]];
        continue;
      end
      w = e_to[e];
      if (lvl[w] >= 0 && lvl[w] == lvl[u] + 1 && spare(e) > 0 && depth < NODES) begin
        path[depth++] = e;
        u = w;
      end else begin
        cur[u] = e_nxt[e];
      end
    end
  endfunction

  function automatic answer_t apply_item(kind_t k, int fr, int to, logic [CAP_W-1:0] c);
    answer_t a;
    int n;
    n = nodes_in_use > NODES ? NODES : nodes_in_use;
    a.status = ST_OK;
    a.flow = '0;
    case (k)
      KIND_ADD: begin
        if (fr >= n || to >= n) a.status = ST_RANGE;
        else if (used_edges + 2 > EDGES) a.status = ST_FULL;
        else begin
          e_to[used_edges] = to;
          e_cap[used_edges] = c;
          e_flow[used_edges] = 0;
          e_to[used_edges + 1] = fr;
          e_cap[used_edges + 1] = '0;
          e_flow[used_edges + 1] = 0;
          chain(fr, used_edges);
          chain(to, used_edges + 1);
          used_edges += 2;
        end
      end
      KIND_SOLVE: begin
        if (src >= n || snk >= n || src == snk) a.status = ST_BAD_ENDS;
        else begin
          if (!have_flow) begin
            have_flow = 1;
            while (levels_reach(src, snk)) push_blocking(src, snk);
          end
          a.flow = flow_sum;
        end
      end
      KIND_CLEAR: wipe_graph();
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst_n) begin
      nodes_in_use <= 7'd64;
      src <= '0;
      snk <= 6'd1;
      wipe_graph();
      answer_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[3:2])
          REG_NODE_COUNT: nodes_in_use <= cfg_pwdata[CNT_W-1:0];
          REG_SOURCE:     src <= cfg_pwdata[NODE_W-1:0];
          REG_SINK:       snk <= cfg_pwdata[NODE_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        answer_q = {answer_q, apply_item(kind_t'(in_tuser), int'(in_tdata[5:0]),
                                         int'(in_tdata[11:6]), in_tdata[43:12])};
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d flow=%0d", $time,
                   out_tdata[1:0], out_tdata[41:2]);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = answer_q.pop_front();
          if (out_tdata[1:0] !== exp_a.status || out_tdata[41:2] !== exp_a.flow) begin
            $display("%0t: mismatch expected status=%0d flow=%0d, actual status=%0d flow=%0d",
                     $time, exp_a.status, exp_a.flow, out_tdata[1:0], out_tdata[41:2]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/max_flow_solver_top_tb.sv @@
`timescale 1ns / 1ps

module max_flow_solver_top_tb;
  import mfs_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0, in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid, out_tready = 0;
  logic [47:0] out_tdata;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending;
  int          send_idle_pct = 0, stall_pct = 0;
  bit          hold_off = 0;
  int          quiet_cycles = 0;

  always #4 clk = ~clk;

  max_flow_solver_top u_top (.*);

  max_flow_solver_checker u_chk (.*);

  always @(negedge clk) begin
    if (hold_off) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // long stretch of backpressure, counted here
  task automatic hold_receiver(int cycles);
    hold_off = 1;
    repeat (cycles) @(negedge clk);
    hold_off = 0;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  // valid stays up after the beat until the next send or a drain drops it
  task automatic send(kind_t k, int fr, int to, logic [31:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= k;
    in_tdata <= {4'b0, c, to[5:0], fr[5:0]};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_cap();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom;
      2: return 32'hffff_ffff;
      default: return $urandom_range(1000);
    endcase
  endfunction

  // one small random graph followed by solves
  task automatic graph_round(int n, int edges);
    send(KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i < edges; i++)
      send(KIND_ADD, $urandom_range(n - 1), $urandom_range(n - 1), rand_cap());
    send(KIND_SOLVE, $urandom, $urandom, $urandom);
    if ($urandom_range(3) == 0) send(KIND_ADD, $urandom_range(63), $urandom_range(63), $urandom);
    send(KIND_SOLVE, 0, 0, 0);
    if ($urandom_range(7) == 0) send(KIND_NOP, $urandom, $urandom, $urandom);
  endtask

  task automatic config_set(int n, int s, int t);
    drain();
    reg_write(REG_NODE_COUNT, n);
    reg_write(REG_SOURCE, s);
    reg_write(REG_SINK, t);
  endtask

  initial begin
    int sent;
    int n;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    // directed: extremes, every kind, special cases
    send(KIND_SOLVE, 0, 0, 0);
    send(KIND_ADD, 0, 1, 32'hffff_ffff);
    send(KIND_ADD, 0, 1, 32'hffff_ffff);
    send(KIND_ADD, 63, 0, 0);
    send(KIND_SOLVE, 0, 0, 0);
    send(KIND_ADD, 0, 1, 5);
    send(KIND_SOLVE, 0, 0, 0);
    send(KIND_NOP, 63, 63, 32'hffff_ffff);
    send(KIND_CLEAR, 0, 0, 0);
    send(KIND_SOLVE, 0, 0, 0);
    config_set(64, 5, 5);
    send(KIND_SOLVE, 0, 0, 0);
    config_set(2, 0, 63);
    send(KIND_SOLVE, 0, 0, 0);
    send(KIND_ADD, 2, 1, 7);
    send(KIND_ADD, 1, 0, 7);
    config_set(127, 63, 0);
    send(KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i < 130; i++) send(KIND_ADD, 63, i % 64, 32'hffff_ffff);
    send(KIND_SOLVE, 0, 0, 0);
    config_set(64, 0, 1);
    // random phases with different idling
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 63; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 63; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      n = (ph == 7) ? 64 : (ph == 0 ? 2 : $urandom_range(3, 12));
      config_set(n, $urandom_range(n - 1), $urandom_range(n - 1));
      if (ph == 2) fork hold_receiver(400); join_none
      while (sent < (ph + 1) * 210) begin
        int m;
        m = (ph == 7 && $urandom_range(3) == 0) ? 130 : $urandom_range(1, 3 * n);
        graph_round(n, m);
        sent += m + 3;
      end
    end
    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
